>>> rtl/core/srkg_pkg.sv
// ----------------------------------------------------------------------------
// srkg_pkg
// Shared constants and controller/datapath interface types for the
// group-reversing stream block.
// ----------------------------------------------------------------------------
package srkg_pkg;

    localparam int VALUE_W      = 32;   // element value width
    localparam int GSIZE_W      = 5;    // group size register width
    localparam int GROUP_MAX_DEF = 16;  // default depth of the group store

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(2);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;    // write the incoming element into the group store
        logic load;     // read the next held element into the output register
    } srkg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush;      // the incoming element completes a group or ends the list
        logic left_zero;  // the element in the output register is the last of the run
    } srkg_status_t;

endpackage

>>> rtl/core/srkg_datapath.sv
// ----------------------------------------------------------------------------
// srkg_datapath
// Group store, fill counter, read address sequencing and output register.
// ----------------------------------------------------------------------------
module srkg_datapath #(
    parameter int GROUP_MAX = srkg_pkg::GROUP_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [srkg_pkg::GSIZE_W-1:0]  cfg_wr_data,
    input  srkg_pkg::srkg_cmd_t           cmd,
    output srkg_pkg::srkg_status_t        status,
    input  logic [srkg_pkg::VALUE_W-1:0]  in_value,
    input  logic                          in_end,
    output logic [srkg_pkg::VALUE_W-1:0]  out_value,
    output logic                          out_last
);
    import srkg_pkg::*;

    localparam int AW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
    localparam int FW = $clog2(GROUP_MAX + 1);
    localparam int CW = (FW > GSIZE_W) ? FW : GSIZE_W;

    logic [VALUE_W-1:0] store_mem [GROUP_MAX];

    logic [GSIZE_W-1:0] gsize_reg;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      left_reg, left_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               rev_reg, rev_next;
    logic               end_reg, end_next;
    logic [VALUE_W-1:0] data_reg;

    logic [CW-1:0]      gsize_ext;
    logic [CW-1:0]      eff_size;
    logic [FW-1:0]      fill_inc;
    logic               group_full;

    // Effective group size: zero acts as one, oversize is capped at the store depth.
    always_comb
    begin
        gsize_ext = CW'(gsize_reg);
        if (gsize_ext == '0)
            eff_size = CW'(1);
        else if (gsize_ext > CW'(GROUP_MAX))
            eff_size = CW'(GROUP_MAX);
        else
            eff_size = gsize_ext;
    end

    assign fill_inc   = fill_reg + FW'(1);
    assign group_full = (CW'(fill_inc) >= eff_size);

    assign status.flush     = group_full | in_end;
    assign status.left_zero = (left_reg == '0);

    always_comb
    begin
        fill_next = fill_reg;
        left_next = left_reg;
        addr_next = addr_reg;
        rev_next  = rev_reg;
        end_next  = end_reg;
        if (cmd.store)
        begin
            if (group_full | in_end)
            begin
                fill_next = '0;
                left_next = fill_inc;
                rev_next  = group_full;
                end_next  = in_end;
                addr_next = group_full ? fill_reg[AW-1:0] : '0;
            end
            else
            begin
                fill_next = fill_inc;
            end
        end
        else if (cmd.load)
        begin
            left_next = left_reg - FW'(1);
            addr_next = rev_reg ? (addr_reg - AW'(1)) : (addr_reg + AW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= GSIZE_RESET;
            fill_reg  <= '0;
            left_reg  <= '0;
            rev_reg   <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                gsize_reg <= cfg_wr_data;
            fill_reg <= fill_next;
            left_reg <= left_next;
            rev_reg  <= rev_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    // Single-port store: written while taking elements, read while draining.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            store_mem[fill_reg[AW-1:0]] <= in_value;
        else if (cmd.load)
            data_reg <= store_mem[addr_reg];
    end

    assign out_value = data_reg;
    assign out_last  = end_reg & (left_reg == '0);

endmodule

>>> rtl/core/srkg_ctrl.sv
// ----------------------------------------------------------------------------
// srkg_ctrl
// Handshake controller: takes elements, then drains a finished group or the remainder of an ended list.
// ----------------------------------------------------------------------------
module srkg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output srkg_pkg::srkg_cmd_t     cmd,
    input  srkg_pkg::srkg_status_t  status
);
    import srkg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.store  = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
                if (in_valid && status.flush)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.load   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.left_zero)
                        state_next = ST_IDLE;
                    else
                        cmd.load = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/core/stream_reverse_in_k_groups.sv
// ----------------------------------------------------------------------------
// stream_reverse_in_k_groups
// Reorders a stream of list elements by reversing each full group.
// ----------------------------------------------------------------------------
// Signed 32-bit list elements arrive one per input transfer, with tlast on the
// final element of a list. Elements are held in a single-port group store;
// once group_size of them are held they leave in reverse order, and when a
// list ends before a group is full, the held remainder leaves in its original
// order. m_axis_tlast marks the final element of the reordered list. A
// group_size of zero acts as one, and one above GROUP_MAX acts as GROUP_MAX.
// Elements are taken while the block is idle. A completed run is then read
// back from the store: a first read loads the output register, and each
// accepted output transfer but the last loads the next element, so the output
// holds while the receiver stalls. The single store port is shared between
// filling and draining, and input is not taken while a run drains.
// group_size may be written only while the block is idle.
// ----------------------------------------------------------------------------
module stream_reverse_in_k_groups #(
    parameter int GROUP_MAX = srkg_pkg::GROUP_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: group_size write.
    input  logic                          cfg_wr_en,
    input  logic [srkg_pkg::GSIZE_W-1:0]  cfg_wr_data,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [srkg_pkg::VALUE_W-1:0]  s_axis_tdata,   // [31:0] elem_value
    input  logic                          s_axis_tlast,   // list_end
    // Output stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [srkg_pkg::VALUE_W-1:0]  m_axis_tdata,   // [31:0] out_value
    output logic                          m_axis_tlast    // out_last
);
    import srkg_pkg::*;

    srkg_cmd_t    cmd;
    srkg_status_t status;

    // The controller sequences fill and drain; the datapath owns the store.
    srkg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    srkg_datapath #(
        .GROUP_MAX (GROUP_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .in_value    (s_axis_tdata),
        .in_end      (s_axis_tlast),
        .out_value   (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

>>> verif/stream_reverse_in_k_groups_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_reverse_in_k_groups_test
// Self-checking testbench for the group-reversing stream block.
// ----------------------------------------------------------------------------
// Lists of signed 32-bit elements are streamed into the block under several
// group sizes, the extremes among them. A scoreboard keeps its own copy of the
// held elements and the group size, works out the reordered transfers that
// each accepted element causes, and checks every output transfer against the
// oldest one still due. Both stream sides idle at random in several phases,
// the receiver holds off once for a long stretch so that the block fills up
// and stalls its input, and the group size is changed only while the block is
// idle, sometimes in the middle of a list.
// ----------------------------------------------------------------------------
module stream_reverse_in_k_groups_test;

    import srkg_pkg::*;

    localparam int GROUP_DEPTH = GROUP_MAX_DEF;
    // Margin after the last due transfer, ample for a full group to drain.
    localparam int DRAIN_SLACK = 2 * GROUP_DEPTH + 8;
    localparam int RANDOM_PER_PHASE = 44;

    // Scoreboard: predicts the reordered stream and checks the block's output.
    class reversed_order_board;
        logic [VALUE_W-1:0] held [GROUP_DEPTH];
        int unsigned        held_count;
        logic [GSIZE_W-1:0] group_size;
        logic [VALUE_W-1:0] due_value [$];
        logic               due_last [$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        lists_ended;
        int unsigned        full_groups;
        int unsigned        partial_tails;

        function new();
            held_count    = 0;
            group_size    = GSIZE_RESET;
            mismatches    = 0;
            results_seen  = 0;
            lists_ended   = 0;
            full_groups   = 0;
            partial_tails = 0;
        endfunction

        function void write_size(input logic [GSIZE_W-1:0] sz);
            group_size = sz;
        endfunction

        // Size of the group actually used: zero acts as one, and anything
        // above the store depth acts as the depth.
        function int unsigned span();
            if (group_size == '0)
                return 1;
            if (group_size > GROUP_DEPTH)
                return GROUP_DEPTH;
            return group_size;
        endfunction

        function int unsigned pending();
            return due_value.size();
        endfunction

        function void note_elem(input logic [VALUE_W-1:0] value, input logic ends_list);
            int unsigned k;
            int unsigned n;
            k = span();
            if (held_count < GROUP_DEPTH)
            begin
                held[held_count] = value;
                held_count++;
            end
            n = held_count;
            if (ends_list)
                lists_ended++;
            if (n >= k)
            begin
                // A completed group leaves newest first; on a list end the
                // flag rides on the oldest element, which leaves last.
                for (int i = 0; i < n; i++)
                begin
                    due_value.push_back(held[n - 1 - i]);
                    due_last.push_back(ends_list && (i == n - 1));
                end
                held_count = 0;
                full_groups++;
            end
            else if (ends_list)
            begin
                // A short tail leaves in arrival order.
                for (int i = 0; i < n; i++)
                begin
                    due_value.push_back(held[i]);
                    due_last.push_back(i == n - 1);
                end
                held_count = 0;
                partial_tails++;
            end
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_out(input logic [VALUE_W-1:0] value, input logic last);
            logic [VALUE_W-1:0] want_value;
            logic               want_last;
            results_seen++;
            if (due_value.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output transfer value %h last %b",
                                          value, last));
            end
            else
            begin
                want_value = due_value.pop_front();
                want_last  = due_last.pop_front();
                if (value !== want_value)
                    report_mismatch($sformatf("out_value %h (%0d), expected %h (%0d)",
                                              value, $signed(value),
                                              want_value, $signed(want_value)));
                if (last !== want_last)
                    report_mismatch($sformatf("out_last %b, expected %b on value %h",
                                              last, want_last, want_value));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [GSIZE_W-1:0]  cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [VALUE_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;

    reversed_order_board board;

    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;
    int size_writes;
    int elems_sent;

    stream_reverse_in_k_groups #(
        .GROUP_MAX(GROUP_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Every output transfer is checked at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            board.check_out(m_axis_tdata, m_axis_tlast);
    end

    initial
    begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Mostly small groups, with the extremes and out-of-range sizes now and then.
    function automatic logic [GSIZE_W-1:0] pick_size();
        case ($urandom_range(0, 11))
            0: return GSIZE_W'(0);
            1: return GSIZE_W'(GROUP_DEPTH);
            2: return GSIZE_W'(GROUP_DEPTH + 1);
            3: return '1;
            4: return GSIZE_W'($urandom_range(0, 31));
            default: return GSIZE_W'($urandom_range(1, 5));
        endcase
    endfunction

    // Offers one element and returns at the edge that accepts it. tvalid is
    // left high so that the next element can follow without a gap.
    task automatic send_elem(input logic [VALUE_W-1:0] value, input logic ends_list);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= ends_list;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        board.note_elem(value, ends_list);
        elems_sent++;
    endtask

    // Stops offering, waits for every due transfer, then lets an element that
    // caused no output settle inside the block.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic set_group_size(input logic [GSIZE_W-1:0] sz);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.write_size(sz);
        size_writes++;
    endtask

    initial
    begin
        int unsigned k;
        int unsigned len;
        int unsigned cut;
        int          sent_in_phase;
        int          idle_plan [4];
        int          stall_plan [4];

        board         = new();
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 0;
        size_writes   = 0;
        elems_sent    = 0;
        idle_plan  = '{0, 79, 0, 13};
        stall_plan = '{0, 0, 79, 13};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The reset size of two is used first: a full group
        // followed by a one-element tail, a full group at the list end, then a one-element list.
        send_elem(32'h7FFF_FFFF, 1'b0);
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'h0000_0000, 1'b1);
        send_elem(32'hFFFF_FFFF, 1'b0);
        send_elem(32'h0000_0001, 1'b1);
        send_elem(32'h0000_0005, 1'b1);

        // A size of zero passes each element straight through.
        wait_drained();
        set_group_size(GSIZE_W'(0));
        send_elem(32'h1234_5678, 1'b1);

        // Size lowered while three elements are held: the fourth flushes all
        // of them as one reversed group, and it also ends the list.
        wait_drained();
        set_group_size(GSIZE_W'(4));
        send_elem(32'hA5A5_0001, 1'b0);
        send_elem(32'h5A5A_0002, 1'b0);
        send_elem(32'hC3C3_0003, 1'b0);
        wait_drained();
        set_group_size(GSIZE_W'(2));
        send_elem(32'h3C3C_0004, 1'b1);

        // All ones in the register acts as the full store depth.
        wait_drained();
        set_group_size('1);
        for (int i = 0; i < GROUP_DEPTH; i++)
            send_elem(pick_value(), i == GROUP_DEPTH - 1);

        // Random lists over the idling phases. The first phase opens with a
        // long receiver hold-off while the sender keeps offering elements.
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            send_idle_pct = idle_plan[phase];
            stall_pct     = stall_plan[phase];
            if (phase == 0)
                hold_req = 300;
            sent_in_phase = 0;
            while (sent_in_phase < RANDOM_PER_PHASE)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    wait_drained();
                    set_group_size(pick_size());
                end
                k   = board.span();
                len = $urandom_range(1, 2 * k + 2);
                cut = 0;
                if (len > 1 && $urandom_range(0, 6) == 0)
                    cut = $urandom_range(1, len - 1);
                for (int j = 0; j < len; j++)
                begin
                    // Occasionally change the size in the middle of a list.
                    if (cut != 0 && j == cut)
                    begin
                        wait_drained();
                        set_group_size(pick_size());
                    end
                    send_elem(pick_value(), j == len - 1);
                    sent_in_phase++;
                end
            end
        end

        wait_drained();

        $display("Sent %0d elements in %0d lists under %0d size writes; checked %0d outputs.",
                 elems_sent, board.lists_ended, size_writes, board.results_seen);
        $display("Reversed %0d full groups and passed %0d short tails in order.",
                 board.full_groups, board.partial_tails);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
